FILE: design/hierarchical_bitmap_set_unit_assert.svh
// ----------------------------------------------------------------------------
// hierarchical bitmap set assertion macros
// shared concurrent assertion forms, clocked on i_clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_SET_UNIT_ASSERT_SVH
`define HIERARCHICAL_BITMAP_SET_UNIT_ASSERT_SVH

// same-cycle implication
`define HBS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbs assertion failed");

// next-cycle implication
`define HBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbs assertion failed");

`endif

FILE: design/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// constants, types and bit helpers for the hierarchical bitmap set
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int UNIVERSE    = 4096;
    localparam int KEY_W       = 12;
    localparam int KEY_SPAN    = 1 << KEY_W;
    localparam int ACTIVE_KEYS = (UNIVERSE < KEY_SPAN) ? UNIVERSE : KEY_SPAN;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int LEAF_AW     = KEY_W - BIT_W;
    localparam int LEAF_WORDS  = (ACTIVE_KEYS + WORD_W - 1) / WORD_W;
    localparam int CMD_W       = 3;

    localparam logic [KEY_W:0]   KEY_LIMIT = (KEY_W + 1)'(ACTIVE_KEYS);
    localparam logic [KEY_W-1:0] KEY_LAST  = KEY_W'(ACTIVE_KEYS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_TEST   = 3'd2,
        CMD_SUCC   = 3'd3,
        CMD_PRED   = 3'd4
    } t_cmd;

    // leaf store write request
    typedef struct packed {
        logic               en;
        logic [LEAF_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } t_wr_req;

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] n;
        n = BIT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) n = BIT_W'(i);
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) n = BIT_W'(i);
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] mask_ge(input logic [BIT_W-1:0] b);
        return {WORD_W{1'b1}} << b;
    endfunction

    function automatic logic [WORD_W-1:0] mask_gt(input logic [BIT_W-1:0] b);
        return mask_ge(b) << 1;
    endfunction

    function automatic logic [WORD_W-1:0] mask_le(input logic [BIT_W-1:0] b);
        return ~mask_gt(b);
    endfunction

    function automatic logic [WORD_W-1:0] mask_lt(input logic [BIT_W-1:0] b);
        return ~mask_ge(b);
    endfunction

endpackage

FILE: design/hbs_leaf_store.sv
// ----------------------------------------------------------------------------
// hbs_leaf_store
// leaf word memory, one write and one registered read port, per-word valid
// bits so that words never written read as zero
// ----------------------------------------------------------------------------
module hbs_leaf_store
    import hbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [LEAF_AW-1:0] i_rd_addr,
    input  t_wr_req            i_wr,
    output logic [WORD_W-1:0]  o_rd_data
);

    logic [WORD_W-1:0]     r_mem [LEAF_WORDS];
    logic [LEAF_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: design/hierarchical_bitmap_set_unit.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_set_unit
// set of 12-bit keys kept as a two-level tree of 64-bit occupancy words
// ----------------------------------------------------------------------------
// The set starts empty after reset and takes one command word at a time:
// insert, erase, test, successor (smallest member at or above the key) and
// predecessor (largest member at or below the key). Updates return nothing;
// the three queries return one word with a found flag and a position, and
// position is zero when nothing is found. Unknown commands are dropped.
// Leaf words live in a single-port-read memory with a registered read
// port; the summary word (one bit per non-empty leaf) sits in flops.
// An item is accepted, then does the leaf read-modify-write or the leaf
// check; a search that has to move to another leaf word adds a second
// read through the same leaf memory port. An unknown command ends with
// its accept step alone. A query holds its last step for as
// long as the previous result still waits for m_tready in the output
// register. No clearing pass is needed after reset: per-word valid bits
// make unwritten leaves read as empty. A new item is taken only once the
// previous one is done, while a finished result may still wait in the
// output register.
module hierarchical_bitmap_set_unit
    import hbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[2:0], key[14:3], zero[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // found[0], position[12:1], zero[15:13]
);

`include "hierarchical_bitmap_set_unit_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LEAF  = 3'b010,
        S_LEAF2 = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic               r_in_range;
    logic [LEAF_AW-1:0] r_w2, n_w2;
    logic [WORD_W-1:0]  r_summary, n_summary;

    logic               r_m_valid;
    logic               r_found;
    logic [KEY_W-1:0]   r_pos;

    // incoming word
    t_cmd               in_cmd;
    logic [KEY_W-1:0]   in_key;
    logic               in_range;
    logic [KEY_W-1:0]   in_key_eff;
    logic               in_go;
    logic               s_accept;

    // leaf store access
    logic               rd_en;
    logic [LEAF_AW-1:0] rd_addr;
    t_wr_req            wr_req;
    logic [WORD_W-1:0]  rd_word;

    // working values in the leaf step
    logic [LEAF_AW-1:0] cur_w;
    logic [BIT_W-1:0]   cur_b;
    logic [WORD_W-1:0]  cur_onehot;
    logic [WORD_W-1:0]  cand_s, cand_p, sum_s, sum_p;
    logic [WORD_W-1:0]  ins_word, ers_word;

    // result load
    logic               out_free;
    logic               res_load;
    logic               res_found;
    logic [KEY_W-1:0]   res_pos;

    hbs_leaf_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr_req),
        .o_rd_data (rd_word)
    );

    assign in_cmd   = t_cmd'(s_tdata[CMD_W-1:0]);
    assign in_key   = s_tdata[CMD_W +: KEY_W];
    assign in_range = ({1'b0, in_key} < KEY_LIMIT);

    // predecessor from beyond the set searches from the last key
    assign in_key_eff = (in_cmd == CMD_PRED && !in_range) ? KEY_LAST : in_key;

    always_comb begin
        case (in_cmd)
            CMD_INSERT, CMD_ERASE:        in_go = in_range;
            CMD_TEST, CMD_SUCC, CMD_PRED: in_go = 1'b1;
            default:                      in_go = 1'b0;
        endcase
    end

    assign s_tready = (r_state == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;

    assign cur_w      = r_key[KEY_W-1:BIT_W];
    assign cur_b      = r_key[BIT_W-1:0];
    assign cur_onehot = WORD_W'(1) << cur_b;
    assign cand_s     = rd_word & mask_ge(cur_b);
    assign cand_p     = rd_word & mask_le(cur_b);
    assign sum_s      = r_summary & mask_gt(BIT_W'(cur_w));
    assign sum_p      = r_summary & mask_lt(BIT_W'(cur_w));
    assign ins_word   = rd_word | cur_onehot;
    assign ers_word   = rd_word & ~cur_onehot;

    always_comb begin
        n_state   = r_state;
        n_w2      = r_w2;
        n_summary = r_summary;
        rd_en     = 1'b0;
        rd_addr   = in_key_eff[KEY_W-1:BIT_W];
        wr_req    = '0;
        res_load  = 1'b0;
        res_found = 1'b0;
        res_pos   = '0;
        case (r_state)
            S_IDLE: begin
                if (s_accept && in_go) begin
                    rd_en   = 1'b1;
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        wr_req.en   = 1'b1;
                        wr_req.addr = cur_w;
                        wr_req.data = ins_word;
                        n_summary[cur_w] = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_ERASE: begin
                        wr_req.en   = 1'b1;
                        wr_req.addr = cur_w;
                        wr_req.data = ers_word;
                        // leaf word emptied: drop its summary mark
                        if (ers_word == '0) n_summary[cur_w] = 1'b0;
                        n_state = S_IDLE;
                    end
                    CMD_TEST: begin
                        if (out_free) begin
                            res_load  = 1'b1;
                            res_found = r_in_range && rd_word[cur_b];
                            res_pos   = res_found ? r_key : '0;
                            n_state   = S_IDLE;
                        end
                    end
                    CMD_SUCC: begin
                        if (r_in_range && cand_s != '0) begin
                            if (out_free) begin
                                res_load  = 1'b1;
                                res_found = 1'b1;
                                res_pos   = {cur_w, low_bit(cand_s)};
                                n_state   = S_IDLE;
                            end
                        end else if (r_in_range && sum_s != '0) begin
                            // next non-empty leaf above this one
                            n_w2    = LEAF_AW'(low_bit(sum_s));
                            rd_en   = 1'b1;
                            rd_addr = n_w2;
                            n_state = S_LEAF2;
                        end else if (out_free) begin
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    CMD_PRED: begin
                        if (cand_p != '0) begin
                            if (out_free) begin
                                res_load  = 1'b1;
                                res_found = 1'b1;
                                res_pos   = {cur_w, high_bit(cand_p)};
                                n_state   = S_IDLE;
                            end
                        end else if (sum_p != '0) begin
                            // nearest non-empty leaf below this one
                            n_w2    = LEAF_AW'(high_bit(sum_p));
                            rd_en   = 1'b1;
                            rd_addr = n_w2;
                            n_state = S_LEAF2;
                        end else if (out_free) begin
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LEAF2: begin
                if (out_free) begin
                    res_load  = 1'b1;
                    res_found = 1'b1;
                    res_pos   = (r_cmd == CMD_SUCC) ? {r_w2, low_bit(rd_word)}
                                                    : {r_w2, high_bit(rd_word)};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_summary <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_summary <= n_summary;
            if (res_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd      <= in_cmd;
            r_key      <= in_key_eff;
            r_in_range <= in_range;
        end
        r_w2 <= n_w2;
        if (res_load) begin
            r_found <= res_found;
            r_pos   <= res_pos;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {3'b000, r_pos, r_found};

    // a miss carries a zero position
    `HBS_ASSERT_IMPL(a_miss_zero_pos, m_tvalid && !m_tdata[0], m_tdata[12:1] == '0)
    // the leaf store never sees a read and a write in one cycle
    `HBS_ASSERT_IMPL(a_single_access, rd_en, !wr_req.en)
    // an insert leaves its leaf marked in the summary
    `HBS_ASSERT_NEXT(a_insert_marks, (r_state == S_LEAF) && (r_cmd == CMD_INSERT), r_summary[cur_w])
    // a leaf reached through the summary is never empty
    `HBS_ASSERT_IMPL(a_leaf2_nonempty, r_state == S_LEAF2, rd_word != '0)

endmodule
